FILE: sv/sti_pkg.sv
// Package for the sorted table block: request and result types, opcodes,
// sequencer states and sizing constants. Used by the top level and the checker.
package sti_pkg;

  localparam int DEPTH = 64;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int OP_W = 2;
  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               error;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_PUT,
    ST_LK_DATA,
    ST_REM_RD,
    ST_REM_WR
  } state_t;

endpackage

FILE: sv/sorted_table_insert_remove_top.sv
// Top level of the sorted table: sequencer, count and capacity registers, APB port.
// Depends on sti_pkg and sti_ram.
//
//   channel   handshake                 payload
//   request   start in, busy out        in_req  (op, value, index)
//   result    out_valid strobe out      out_rsp (read_value, error, count)
//   config    psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// A refused request gives its result in the cycle after it is taken. A lookup reads
// the RAM and then gives the entry. An insert into an empty table writes entry 0 at
// once; otherwise it reads entries from the top down, moves each one up while it is
// not below the new value, then writes the value into the gap. A remove of the last
// entry only lowers the count; otherwise each later entry is read and moved down.
// Reset is synchronous and needs no clearing pass. The receiver cannot stall.
module sorted_table_insert_remove_top #(
  parameter int DEPTH = sti_pkg::DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  sti_pkg::req_t                 in_req,
  output logic                          out_valid,
  output sti_pkg::rsp_t                 out_rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = sti_pkg::COUNT_W;

  sti_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cap_r;
  sti_pkg::req_t req_r, req_nxt;
  logic out_valid_r, out_valid_nxt;
  sti_pkg::rsp_t out_rsp_r, out_rsp_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [sti_pkg::VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [sti_pkg::VALUE_W-1:0] ram_rdata;

  logic full;
  logic idx_bad;

  function automatic sti_pkg::rsp_t mk_rsp(logic [sti_pkg::VALUE_W-1:0] rv, logic e,
                                            logic [CW-1:0] c);
    sti_pkg::rsp_t r;
    r.read_value = rv;
    r.error = e;
    r.count = c;
    return r;
  endfunction

  sti_ram #(
    .WIDTH(sti_pkg::VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign full = (count_r >= cap_r) || (32'(count_r) >= 32'(DEPTH));
  assign idx_bad = CW'(in_req.index) >= count_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    count_nxt = count_r;
    req_nxt = req_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt = out_rsp_r;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      sti_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          case (in_req.op)
            sti_pkg::OP_INSERT: begin
              if (full) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt = mk_rsp('0, 1'b1, count_r);
              end else if (count_r == '0) begin
                ram_we = 1'b1;
                ram_wdata = in_req.value;
                count_nxt = count_r + CW'(1);
                out_valid_nxt = 1'b1;
                out_rsp_nxt = mk_rsp('0, 1'b0, count_nxt);
              end else begin
                k_nxt = count_r;
                state_nxt = sti_pkg::ST_INS_RD;
              end
            end
            sti_pkg::OP_LOOKUP: begin
              if (idx_bad) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt = mk_rsp('0, 1'b1, count_r);
              end else begin
                ram_raddr = AW'(in_req.index);
                state_nxt = sti_pkg::ST_LK_DATA;
              end
            end
            sti_pkg::OP_REMOVE: begin
              if (idx_bad) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt = mk_rsp('0, 1'b1, count_r);
              end else if (CW'(in_req.index) + CW'(1) >= count_r) begin
                count_nxt = count_r - CW'(1);
                out_valid_nxt = 1'b1;
                out_rsp_nxt = mk_rsp('0, 1'b0, count_nxt);
              end else begin
                k_nxt = CW'(in_req.index);
                state_nxt = sti_pkg::ST_REM_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt = mk_rsp('0, 1'b1, count_r);
            end
          endcase
        end
      end
      sti_pkg::ST_INS_RD: begin
        ram_raddr = AW'(k_r - CW'(1));
        state_nxt = sti_pkg::ST_INS_CHK;
      end
      sti_pkg::ST_INS_CHK: begin
        ram_we = 1'b1;
        ram_waddr = AW'(k_r);
        if (ram_rdata >= req_r.value) begin
          ram_wdata = ram_rdata;
          k_nxt = k_r - CW'(1);
          if (k_r == CW'(1)) begin
            state_nxt = sti_pkg::ST_INS_PUT;
          end else begin
            state_nxt = sti_pkg::ST_INS_RD;
          end
        end else begin
          ram_wdata = req_r.value;
          count_nxt = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_rsp_nxt = mk_rsp('0, 1'b0, count_nxt);
          state_nxt = sti_pkg::ST_IDLE;
        end
      end
      sti_pkg::ST_INS_PUT: begin
        ram_we = 1'b1;
        ram_waddr = AW'(k_r);
        ram_wdata = req_r.value;
        count_nxt = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_rsp_nxt = mk_rsp('0, 1'b0, count_nxt);
        state_nxt = sti_pkg::ST_IDLE;
      end
      sti_pkg::ST_LK_DATA: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt = mk_rsp(ram_rdata, 1'b0, count_r);
        state_nxt = sti_pkg::ST_IDLE;
      end
      sti_pkg::ST_REM_RD: begin
        ram_raddr = AW'(k_r + CW'(1));
        state_nxt = sti_pkg::ST_REM_WR;
      end
      sti_pkg::ST_REM_WR: begin
        ram_we = 1'b1;
        ram_waddr = AW'(k_r);
        ram_wdata = ram_rdata;
        k_nxt = k_r + CW'(1);
        if ({1'b0, k_r} + (CW+1)'(2) < {1'b0, count_r}) begin
          state_nxt = sti_pkg::ST_REM_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_rsp_nxt = mk_rsp('0, 1'b0, count_nxt);
          state_nxt = sti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sti_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sti_pkg::ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sti_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cap_r <= pwdata[CW-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, cap_r};
  assign pready = 1'b1;
  assign busy = (state_r != sti_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp = out_rsp_r;

endmodule

FILE: sv/sti_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module sti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/sti_chk.sv
// Port-level checker for the sorted table top level, attached by a bind.
// Depends on sti_pkg and sorted_table_insert_remove_top.
module sti_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input sti_pkg::req_t in_req,
  input logic          out_valid,
  input sti_pkg::rsp_t out_rsp
);

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!out_valid && !busy))
    else $error("Result or busy seen right after reset.");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.error) |-> (out_rsp.read_value == '0))
    else $error("Refused request returned nonzero data.");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result strobe while the sequencer is still busy.");

  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.op != sti_pkg::OP_INSERT &&
     in_req.op != sti_pkg::OP_LOOKUP && in_req.op != sti_pkg::OP_REMOVE)
    |=> (out_valid && out_rsp.error))
    else $error("Unused opcode did not give an immediate error.");

endmodule

bind sorted_table_insert_remove_top sti_chk u_sti_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_req   (in_req),
  .out_valid(out_valid),
  .out_rsp  (out_rsp)
);
